// ===== hdl/csr_element_gather_by_search_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef CSR_ELEMENT_GATHER_BY_SEARCH_ASSERT_SVH
`define CSR_ELEMENT_GATHER_BY_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CEGS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cegs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CEGS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cegs assertion failed");

`endif

// ===== hdl/cegs_pkg.sv =====
package cegs_pkg;

  // Default table sizes.
  localparam int unsigned MAX_ROWS_DEF    = 1024;
  localparam int unsigned MAX_ENTRIES_DEF = 4096;

  // Request field widths.
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 13;
  localparam int ROW_W   = 10;
  localparam int COL_W   = 16;
  localparam int WORD_W  = 32;
  localparam int START_W = 13;

  // Request commands.
  localparam logic [CMD_W-1:0] CMD_WR_ROW = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_ENT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_row;    // store a row start from the request
    logic wr_ent;    // store an entry column and value from the request
    logic capture;   // latch the query row and column
    logic rs_rd;     // read the row start table
    logic rs_next;   // read address is row + 1 instead of row
    logic lo_load;   // load the window low bound from the row start read
    logic win_upd;   // update the search window
    logic win_step;  // window follows the last probe instead of the row bounds
    logic probe_rd;  // read the entry tables at the window midpoint
    logic res_hit;   // hold the probed value as the answer
    logic res_miss;  // hold zero as the answer
    logic out_load;  // move the answer to the output register
  } cegs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_ok;    // requested row is inside the table
    logic win_open;  // next window is not empty
    logic match;     // probed column equals the queried column
    logic out_free;  // output register can take an answer this cycle
  } cegs_sts_t;

endpackage

// ===== hdl/csr_element_gather_by_search.sv =====
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------------
// in       | in_valid / in_stall | in_cmd, in_slot, in_row, in_col, in_word
// out      | out_valid/out_stall | out_grad_bits, out_found
//
// A table write request is stored in the cycle it is accepted. A query reads the
// row start table twice, then makes P search probes, at most ceil(log2(n + 1)) for
// a row of n entries; the single read port of each table sets this sequence.
// A query for a row past the table skips the search and goes straight to done.
// Reset clears only the controller and the output valid; tables are not cleared.
// A query answer waits in the done state while the output register is stalled.
module csr_element_gather_by_search import cegs_pkg::*; #(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [COL_W-1:0]  in_col,
  input  logic [WORD_W-1:0] in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_grad_bits,
  output logic              out_found
);

  cegs_cmd_t cmd;
  cegs_sts_t sts;

  // Sequencer.
  cegs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables, search window and output register.
  cegs_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_slot       (in_slot),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_grad_bits (out_grad_bits),
    .out_found     (out_found)
  );

endmodule

// ===== hdl/cegs_dp.sv =====
module cegs_dp import cegs_pkg::*; #(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cegs_cmd_t         cmd,
  output cegs_sts_t         sts,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [COL_W-1:0]  in_col,
  input  logic [WORD_W-1:0] in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_grad_bits,
  output logic              out_found
);

  // Address widths of the three tables and of the search window bounds.
  localparam int RAW = $clog2(MAX_ROWS + 1);
  localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int WW  = $clog2(MAX_ENTRIES + 1);

  logic [START_W-1:0] rs_mem  [0:MAX_ROWS];
  logic [COL_W-1:0]   col_mem [0:MAX_ENTRIES-1];
  logic [WORD_W-1:0]  val_mem [0:MAX_ENTRIES-1];

  logic [START_W-1:0] rs_data_r;
  logic [COL_W-1:0]   col_data_r;
  logic [WORD_W-1:0]  val_data_r;

  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic [WW-1:0]      lo_r;
  logic [WW-1:0]      hi_r;
  logic [WW-1:0]      mid_r;
  logic [WORD_W-1:0]  res_bits_r;
  logic               res_hit_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [WORD_W-1:0]  out_bits_r;
  logic               out_found_r;

  logic               rs_wr_ok;
  logic               ent_wr_ok;
  logic [RAW-1:0]     rs_addr;
  logic [WW-1:0]      win_lo;
  logic [WW-1:0]      win_hi;
  logic [WW-1:0]      win_mid;
  logic               probe_below;

  // Row starts past the entry table are clamped to its end.
  function automatic logic [WW-1:0] clamp_start(input logic [START_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'(MAX_ENTRIES)) begin
      w = 32'(MAX_ENTRIES);
    end
    return WW'(w);
  endfunction

  // Write address range checks; out-of-range writes are dropped.
  assign rs_wr_ok  = (32'(in_slot) <= 32'(MAX_ROWS));
  assign ent_wr_ok = (32'(in_slot) < 32'(MAX_ENTRIES));

  // Row start table: one write port, one registered read port.
  assign rs_addr = cmd.rs_next ? RAW'(32'(row_r) + 32'd1) : RAW'(row_r);

  always_ff @(posedge clk) begin
    if (cmd.wr_row && rs_wr_ok) begin
      rs_mem[RAW'(in_slot)] <= in_word[START_W-1:0];
    end
    if (cmd.rs_rd) begin
      rs_data_r <= rs_mem[rs_addr];
    end
  end

  // Next search window: the row bounds, or the half left after a probe.
  assign probe_below = (col_data_r < col_r);

  always_comb begin
    if (!cmd.win_step) begin
      win_lo = lo_r;
      win_hi = clamp_start(rs_data_r);
    end else if (probe_below) begin
      win_lo = mid_r + WW'(1);
      win_hi = hi_r;
    end else begin
      win_lo = lo_r;
      win_hi = mid_r;
    end
  end

  assign win_mid = win_lo + ((win_hi - win_lo) >> 1);

  // Entry tables share the probe address.
  always_ff @(posedge clk) begin
    if (cmd.wr_ent && ent_wr_ok) begin
      col_mem[EAW'(in_slot)] <= in_col;
    end
    if (cmd.probe_rd) begin
      col_data_r <= col_mem[EAW'(win_mid)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_ent && ent_wr_ok) begin
      val_mem[EAW'(in_slot)] <= in_word;
    end
    if (cmd.probe_rd) begin
      val_data_r <= val_mem[EAW'(win_mid)];
    end
  end

  // Query registers, window bounds and the held answer.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    if (cmd.lo_load) begin
      lo_r <= clamp_start(rs_data_r);
    end
    if (cmd.win_upd) begin
      lo_r <= win_lo;
      hi_r <= win_hi;
    end
    if (cmd.probe_rd) begin
      mid_r <= win_mid;
    end
    if (cmd.res_hit) begin
      res_bits_r <= val_data_r;
      res_hit_r  <= 1'b1;
    end else if (cmd.res_miss) begin
      res_bits_r <= '0;
      res_hit_r  <= 1'b0;
    end
  end

  // Output register: holds one answer until the consumer takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_bits_r  <= res_bits_r;
      out_found_r <= res_hit_r;
    end
  end

  // Status back to the controller.
  assign sts.row_ok   = (32'(in_row) < 32'(MAX_ROWS));
  assign sts.win_open = (win_lo < win_hi);
  assign sts.match    = (col_data_r == col_r);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_grad_bits = out_bits_r;
  assign out_found     = out_found_r;

endmodule

// ===== hdl/cegs_ctrl.sv =====
module cegs_ctrl import cegs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_cmd,
  input  cegs_sts_t        sts,
  output cegs_cmd_t        cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RD_LO = 6'b000010,
    ST_RD_HI = 6'b000100,
    ST_WIN   = 6'b001000,
    ST_PROBE = 6'b010000,
    ST_DONE  = 6'b100000
  } cegs_state_t;

  cegs_state_t state_r;
  cegs_state_t state_nxt;
  logic        accept;

  // Requests are taken only between queries.
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  // Sequencing: two row start reads, then one probe per cycle.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_WR_ROW: cmd.wr_row = 1'b1;
            CMD_WR_ENT: cmd.wr_ent = 1'b1;
            CMD_QUERY: begin
              cmd.capture = 1'b1;
              if (sts.row_ok) begin
                state_nxt = ST_RD_LO;
              end else begin
                cmd.res_miss = 1'b1;
                state_nxt    = ST_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD_LO: begin
        cmd.rs_rd = 1'b1;
        state_nxt = ST_RD_HI;
      end
      ST_RD_HI: begin
        cmd.lo_load = 1'b1;
        cmd.rs_rd   = 1'b1;
        cmd.rs_next = 1'b1;
        state_nxt   = ST_WIN;
      end
      ST_WIN: begin
        cmd.win_upd = 1'b1;
        if (sts.win_open) begin
          cmd.probe_rd = 1'b1;
          state_nxt    = ST_PROBE;
        end else begin
          cmd.res_miss = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_PROBE: begin
        if (sts.match) begin
          cmd.res_hit = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          cmd.win_step = 1'b1;
          cmd.win_upd  = 1'b1;
          if (sts.win_open) begin
            cmd.probe_rd = 1'b1;
          end else begin
            cmd.res_miss = 1'b1;
            state_nxt    = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/cegs_checker.sv =====
`include "csr_element_gather_by_search_assert.svh"

module cegs_checker import cegs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [CMD_W-1:0]  in_cmd,
  input logic              out_valid,
  input logic              out_stall,
  input logic [WORD_W-1:0] out_grad_bits,
  input logic              out_found
);

  logic in_take;
  logic out_wait;

  assign in_take  = in_valid && !in_stall;
  assign out_wait = out_valid && out_stall;

  // A query holds off further requests while it searches.
  `CEGS_ASSERT_NEXT(a_query_blocks, in_take && (in_cmd == CMD_QUERY), in_stall)

  // A table write never produces an answer.
  `CEGS_ASSERT_NEXT(a_write_silent, in_take && (in_cmd != CMD_QUERY) && !out_valid, !out_valid)

  // A miss always reports zero value bits.
  `CEGS_ASSERT_NOW(a_miss_zero, out_valid && !out_found, out_grad_bits == '0)

  // A stalled answer stays put.
  `CEGS_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_grad_bits) && $stable(out_found))

endmodule

bind csr_element_gather_by_search cegs_checker u_cegs_checker (.*);

// ===== bench/tb_csr_element_gather_by_search.sv =====
module tb_csr_element_gather_by_search;
  import cegs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ROWS    = MAX_ROWS_DEF;
  localparam int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned USEFUL_TARGET = 400;
  localparam int unsigned CALM_FROM     = 340;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 40;

  // One request as it is sent, plus an optional hand-typed answer for queries.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [WORD_W-1:0] word;
    logic              typed;
    logic [WORD_W-1:0] exp_bits;
    logic              exp_found;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] grad_bits;
    logic              found;
  } answer_t;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_cmd    = '0;
  logic [SLOT_W-1:0] in_slot   = '0;
  logic [ROW_W-1:0]  in_row    = '0;
  logic [COL_W-1:0]  in_col    = '0;
  logic [WORD_W-1:0] in_word   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_grad_bits;
  logic              out_found;

  csr_element_gather_by_search dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_slot       (in_slot),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_grad_bits (out_grad_bits),
    .out_found     (out_found)
  );

  // Shadow copy of the CSR tables and which locations have been written.
  logic [START_W-1:0] row_start_tbl [0:MAX_ROWS];
  logic [COL_W-1:0]   ent_col       [0:MAX_ENTRIES-1];
  logic [WORD_W-1:0]  ent_val       [0:MAX_ENTRIES-1];
  bit                 rs_written    [0:MAX_ROWS];
  bit                 ent_written   [0:MAX_ENTRIES-1];

  answer_t     answer_q [$];
  int unsigned err_cnt = 0;
  int unsigned useful_cnt = 0;
  int unsigned n_writes = 0;
  int unsigned n_ignored = 0;
  int unsigned n_hits = 0;
  int unsigned n_misses = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A row start is clamped to the end of the entry table before the search.
  function automatic int unsigned win_bound(input logic [START_W-1:0] s);
    return (s > MAX_ENTRIES) ? MAX_ENTRIES : int'(s);
  endfunction

  // Binary search of one row. Returns 0 if the search would touch a table
  // location that was never written, so such a query is never sent.
  function automatic bit lookup_element(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                        output logic [WORD_W-1:0] grad_bits,
                                        output logic found);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    grad_bits = '0;
    found     = 1'b0;
    if (r >= MAX_ROWS) return 1'b1;
    if (!rs_written[r] || !rs_written[int'(r) + 1]) return 1'b0;
    lo = win_bound(row_start_tbl[r]);
    hi = win_bound(row_start_tbl[int'(r) + 1]);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (!ent_written[mid]) return 1'b0;
      if (ent_col[mid] == c) begin
        grad_bits = ent_val[mid];
        found     = 1'b1;
        return 1'b1;
      end else if (ent_col[mid] < c) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return 1'b1;
  endfunction

  function automatic req_t mk_req(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                  input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                                  input logic [WORD_W-1:0] word);
    req_t r;
    r = '0;
    r.cmd  = cmd;
    r.slot = slot;
    r.row  = row;
    r.col  = col;
    r.word = word;
    return r;
  endfunction

  // Send one request, wait for it to be taken, then update the shadow tables
  // or queue the answer the block owes for it.
  task automatic issue(input req_t r);
    answer_t a;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= r.cmd;
    in_slot  <= r.slot;
    in_row   <= r.row;
    in_col   <= r.col;
    in_word  <= r.word;
    do @(posedge clk); while (in_stall);
    case (r.cmd)
      CMD_WR_ROW: begin
        if (r.slot <= MAX_ROWS) begin
          row_start_tbl[r.slot] = r.word[START_W-1:0];
          rs_written[r.slot]    = 1'b1;
          n_writes++;
          useful_cnt++;
        end else begin
          n_ignored++;
        end
      end
      CMD_WR_ENT: begin
        if (r.slot < MAX_ENTRIES) begin
          ent_col[r.slot]     = r.col;
          ent_val[r.slot]     = r.word;
          ent_written[r.slot] = 1'b1;
          n_writes++;
          useful_cnt++;
        end else begin
          n_ignored++;
        end
      end
      CMD_QUERY: begin
        void'(lookup_element(r.row, r.col, a.grad_bits, a.found));
        if (r.typed) begin
          a.grad_bits = r.exp_bits;
          a.found     = r.exp_found;
        end
        if (a.found) n_hits++;
        else n_misses++;
        answer_q.push_back(a);
        useful_cnt++;
      end
      default: n_ignored++;
    endcase
  endtask

  // Load a few consecutive rows with a fresh run of entries, then query them.
  task automatic build_rows_and_query();
    int unsigned nrows;
    int unsigned base_row;
    int unsigned total;
    int unsigned ent_base;
    int unsigned pos;
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    int unsigned cnt [4];
    bit          at_end;
    bit          sorted;
    logic [COL_W-1:0]  cols [$];
    logic [COL_W-1:0]  c;
    logic [WORD_W-1:0] w;
    answer_t           a;
    nrows    = $urandom_range(1, 4);
    base_row = $urandom_range(0, MAX_ROWS - nrows);
    total    = 0;
    for (int i = 0; i < nrows; i++) begin
      cnt[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      total += cnt[i];
    end
    at_end   = ($urandom_range(0, 9) == 0);
    ent_base = at_end ? MAX_ENTRIES - total : $urandom_range(0, MAX_ENTRIES - total);
    sorted   = ($urandom_range(0, 9) != 0);

    // Row starts; the last one may point past the table, and junk may sit
    // above the stored bits.
    pos = ent_base;
    for (int i = 0; i <= nrows; i++) begin
      w = pos;
      if (i == nrows && at_end) w = $urandom_range(MAX_ENTRIES, (1 << START_W) - 1);
      if ($urandom_range(0, 3) == 0) w[WORD_W-1:START_W] = (WORD_W-START_W)'($urandom);
      issue(mk_req(CMD_WR_ROW, SLOT_W'(base_row + i), ROW_W'($urandom), COL_W'($urandom),
                   w));
      if (i < nrows) pos += cnt[i];
    end

    // Entries of each row, ascending columns unless this block is scrambled.
    pos = ent_base;
    for (int i = 0; i < nrows; i++) begin
      cols.delete();
      for (int j = 0; j < cnt[i]; j++) begin
        case ($urandom_range(0, 7))
          0:       c = '0;
          1:       c = '1;
          2, 3:    c = COL_W'($urandom_range(0, 15));
          default: c = COL_W'($urandom);
        endcase
        cols.push_back(c);
      end
      if (sorted) cols.sort();
      for (int j = 0; j < cnt[i]; j++) begin
        issue(mk_req(CMD_WR_ENT, SLOT_W'(pos + j), ROW_W'($urandom), cols[j], $urandom));
      end
      pos += cnt[i];
    end

    // Queries: mostly columns that are present, some near misses, some random.
    repeat ($urandom_range(2, 8)) begin
      r  = base_row + $urandom_range(0, nrows - 1);
      lo = win_bound(row_start_tbl[r]);
      hi = win_bound(row_start_tbl[r + 1]);
      case ($urandom_range(0, 3))
        0, 1:    c = (hi > lo) ? ent_col[$urandom_range(lo, hi - 1)] : COL_W'($urandom);
        2:       c = (hi > lo) ? ent_col[$urandom_range(lo, hi - 1)] + 1'b1 : COL_W'($urandom);
        default: c = COL_W'($urandom);
      endcase
      if (lookup_element(ROW_W'(r), c, a.grad_bits, a.found)) begin
        issue(mk_req(CMD_QUERY, SLOT_W'($urandom), ROW_W'(r), c, $urandom));
      end
    end
  endtask

  // Result side: compare each taken answer and stall in random bursts.
  initial begin : result_check
    answer_t     exp_a;
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $error("unexpected result: grad_bits %h found %b", out_grad_bits, out_found);
          err_cnt++;
        end else begin
          exp_a = answer_q.pop_front();
          if (out_grad_bits !== exp_a.grad_bits) begin
            $error("grad_bits: expected %h, actual %h", exp_a.grad_bits, out_grad_bits);
            err_cnt++;
          end
          if (out_found !== exp_a.found) begin
            $error("found: expected %b, actual %b", exp_a.found, out_found);
            err_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any request or result being taken.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: %0d answers still outstanding", answer_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    req_t    dir_tbl [25];
    answer_t a;
    req_t    q;

    // Directed requests: extremes, each command, and the special windows.
    dir_tbl = '{
      '{CMD_WR_ROW, 13'd0,    10'd0,    16'h0000, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      // Upper bits of a row start are dropped: this stores 3.
      '{CMD_WR_ROW, 13'd1,    10'd0,    16'h0000, 32'hFFFF_E003, 1'b0, 32'h0,         1'b0},
      '{CMD_WR_ENT, 13'd0,    10'd0,    16'h0000, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{CMD_WR_ENT, 13'd1,    10'd0,    16'h1234, 32'hDEAD_BEEF, 1'b0, 32'h0,         1'b0},
      '{CMD_WR_ENT, 13'd2,    10'd0,    16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{CMD_QUERY,  13'd0,    10'd0,    16'hFFFF, 32'h0,         1'b1, 32'hFFFF_FFFF, 1'b1},
      '{CMD_QUERY,  13'd0,    10'd0,    16'h0000, 32'h0,         1'b1, 32'h0000_0000, 1'b1},
      '{CMD_QUERY,  13'd0,    10'd0,    16'h1234, 32'h0,         1'b1, 32'hDEAD_BEEF, 1'b1},
      '{CMD_QUERY,  13'd0,    10'd0,    16'h1235, 32'h0,         1'b1, 32'h0000_0000, 1'b0},
      // Row 1 becomes empty, row 2 reversed.
      '{CMD_WR_ROW, 13'd2,    10'd0,    16'h0000, 32'h0000_0003, 1'b0, 32'h0,         1'b0},
      '{CMD_QUERY,  13'd0,    10'd1,    16'h0000, 32'h0,         1'b1, 32'h0000_0000, 1'b0},
      '{CMD_WR_ROW, 13'd3,    10'd0,    16'h0000, 32'h0000_0001, 1'b0, 32'h0,         1'b0},
      '{CMD_QUERY,  13'd0,    10'd2,    16'h1234, 32'h0,         1'b1, 32'h0000_0000, 1'b0},
      // Last row ends past the table and is clamped.
      '{CMD_WR_ROW, 13'd1024, 10'd0,    16'h0000, 32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{CMD_WR_ROW, 13'd1023, 10'd0,    16'h0000, 32'h0000_0FFE, 1'b0, 32'h0,         1'b0},
      '{CMD_WR_ENT, 13'd4095, 10'd0,    16'h0007, 32'h8000_0001, 1'b0, 32'h0,         1'b0},
      '{CMD_WR_ENT, 13'd4094, 10'd0,    16'h0005, 32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{CMD_QUERY,  13'd0,    10'd1023, 16'h0007, 32'h0,         1'b0, 32'h0,         1'b0},
      // Writes out of range and the unused command must change nothing.
      '{CMD_WR_ROW, 13'd1025, 10'd0,    16'h0000, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{CMD_WR_ROW, 13'h1FFF, 10'd0,    16'h0000, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{CMD_WR_ENT, 13'd4096, 10'd0,    16'h00FF, 32'h5A5A_5A5A, 1'b0, 32'h0,         1'b0},
      '{CMD_UNUSED, 13'h1FFF, 10'h3FF,  16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{CMD_QUERY,  13'd0,    10'd1023, 16'h0005, 32'h0,         1'b0, 32'h0,         1'b0},
      '{CMD_QUERY,  13'd0,    10'd0,    16'h0000, 32'h0,         1'b1, 32'h0000_0000, 1'b1},
      '{CMD_QUERY,  13'd0,    10'd0,    16'h1234, 32'h0,         1'b1, 32'hDEAD_BEEF, 1'b1}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) issue(dir_tbl[i]);

    // Random part: mostly well-formed row blocks, some stray traffic.
    while (useful_cnt < USEFUL_TARGET) begin
      if (useful_cnt >= CALM_FROM) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          repeat ($urandom_range(1, 4)) begin
            issue(mk_req($urandom_range(0, 1) ? CMD_WR_ENT : CMD_WR_ROW,
                         SLOT_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
                         $urandom));
          end
        end
        3: begin
          q = mk_req(CMD_QUERY, SLOT_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
                     $urandom);
          if (lookup_element(q.row, q.col, a.grad_bits, a.found)) issue(q);
          issue(mk_req(CMD_UNUSED, SLOT_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
                       $urandom));
        end
        default: build_rows_and_query();
      endcase
    end

    // Let the outstanding answers drain, then a little longer.
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d table writes and %0d ignored requests.", n_writes, n_ignored);
    $display("Queries checked: %0d found, %0d absent.", n_hits, n_misses);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
